### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// antecedent holds -> consequent holds in the same cycle
`define AST_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// antecedent holds -> consequent holds in the next cycle
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define AST_IMPL(lbl, ante, cons)
`define AST_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/xxh_pkg.sv
// Shared types and constants for the streaming xxHash32 core.
// No dependencies; used by xxh_ctrl, xxh_dpath and xxhash32_stream_core.
package xxh_pkg;

    localparam logic [31:0] P1 = 32'd2654435761;
    localparam logic [31:0] P2 = 32'd2246822519;
    localparam logic [31:0] P3 = 32'd3266489917;
    localparam logic [31:0] P4 = 32'd668265263;
    localparam logic [31:0] P5 = 32'd374761393;

    localparam int BUF_DEPTH = 3;

    // datapath micro-operations
    typedef enum logic [4:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_START_STRIPE,
        DP_LANE_MUL,
        DP_LANE_ADD,
        DP_MUL_P1,
        DP_LANE_STORE,
        DP_MERGE,
        DP_ADD_LEN,
        DP_WT_MUL,
        DP_WT_ADD,
        DP_MUL_P4,
        DP_MOVE,
        DP_BT_MUL,
        DP_BT_ADD,
        DP_AV_XOR,
        DP_MUL_P2,
        DP_AV_MIX,
        DP_MUL_P3,
        DP_FINISH
    } dp_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_LANE_MUL,
        S_LANE_ADD,
        S_LANE_MUL1,
        S_LANE_STORE,
        S_MERGE,
        S_ADD_LEN,
        S_WT_MUL,
        S_WT_ADD,
        S_WT_MUL4,
        S_WT_MOVE,
        S_BT_MUL,
        S_BT_ADD,
        S_BT_MUL1,
        S_BT_MOVE,
        S_AV_XOR,
        S_AV_MUL2,
        S_AV_MIX,
        S_AV_MUL3,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] sel;    // lane / word / byte index
    } ctrl_cmd_t;

    typedef struct packed {
        logic       absorb; // current word completed a stripe
        logic       last;   // current word ends the message
        logic [1:0] fill;   // words waiting in the stripe buffer
        logic [2:0] cnt;    // effective byte count of current word
    } dp_stat_t;

endpackage

### hw/rtl/xxhash32_stream_core.sv
// Streaming XXH32 core. A word that completes a 16-byte stripe first runs
// 4 lane rounds x 4 steps. A last word then runs merge, length add, word tails
// (0..3), byte tails (0..3) and the avalanche before out_valid rises.
// All rounds share one 32x32 multiplier.
// rst_n is asynchronous, active low: seed 0, empty message, no result pending.
`include "assert_macros.svh"

module xxhash32_stream_core
(
    input  logic        clk,
    input  logic        rst_n,
    // seed write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] seed,
    // message word requests
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  byte_count,
    input  logic        last_word,
    // hash results
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] hash_value
);

    xxh_pkg::ctrl_cmd_t cmd;
    xxh_pkg::dp_stat_t  dp_stat;

    // The seed register sits in the datapath and is always writable; it is
    // sampled when a message's first stripe completes or at the finish of a
    // message shorter than one stripe.
    assign cfg_ready = 1'b1;

    // Controller: one request is taken in the idle state; the next cycle
    // decides between a stripe update, the finishing sequence, or going back
    // to idle. The finished hash waits in an output register, so a new
    // message may start while the previous result is still unclaimed.
    xxh_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (dp_stat),
        .cmd       (cmd)
    );

    // Datapath: four lane accumulators, three-word stripe buffer, running
    // byte length, the hash work register and the shared multiplier.
    xxh_dpath u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_seed   (seed),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last_word  (last_word),
        .cmd        (cmd),
        .stat       (dp_stat),
        .hash_value (hash_value)
    );

    // after a taken request the sequencer is busy in the next cycle
    `AST_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)
    // a word that completes a stripe leaves the buffer empty
    `AST_IMPL(a_fill_after_stripe, dp_stat.absorb, dp_stat.fill == 2'd0)
    // only a last word that did not feed a stripe carries a short count
    `AST_IMPL(a_short_count_last, dp_stat.cnt != 3'd4, dp_stat.last && !dp_stat.absorb)

endmodule

### hw/rtl/xxh_ctrl.sv
// Sequencer for the xxHash32 core: walks stripe rounds, tails and avalanche.
// Depends on xxh_pkg; drives xxh_dpath through ctrl_cmd_t, reads dp_stat_t.
module xxh_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  xxh_pkg::dp_stat_t  stat,
    output xxh_pkg::ctrl_cmd_t cmd
);

    xxh_pkg::ctrl_state_t state_reg, state_next;
    logic [1:0]           idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 can_load;
    logic                 fwt;
    logic                 bt_any;
    logic [2:0]           cand;
    logic [2:0]           pick;   // {found, index}

    assign can_load = !out_valid_reg || out_ready;
    // full last word not consumed by a stripe -> one more word tail
    assign fwt      = stat.last && !stat.absorb && (stat.cnt == 3'd4);
    assign bt_any   = (stat.cnt != 3'd4) && (stat.cnt != 3'd0);

    // next word-tail source: buffered words first, then the last word itself
    always_comb
    begin
        cand = (state_reg == xxh_pkg::S_WT_MOVE) ? ({1'b0, idx_reg} + 3'd1) : 3'd0;
        if (cand < {1'b0, stat.fill})
            pick = {1'b1, cand[1:0]};
        else if (fwt && (cand <= 3'd3))
            pick = {1'b1, 2'd3};
        else
            pick = 3'd0;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            xxh_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = xxh_pkg::S_DISPATCH;
            end
            xxh_pkg::S_DISPATCH:
            begin
                idx_next = 2'd0;
                if (stat.absorb)
                    state_next = xxh_pkg::S_LANE_MUL;
                else if (stat.last)
                    state_next = xxh_pkg::S_MERGE;
                else
                    state_next = xxh_pkg::S_IDLE;
            end
            xxh_pkg::S_LANE_MUL:  state_next = xxh_pkg::S_LANE_ADD;
            xxh_pkg::S_LANE_ADD:  state_next = xxh_pkg::S_LANE_MUL1;
            xxh_pkg::S_LANE_MUL1: state_next = xxh_pkg::S_LANE_STORE;
            xxh_pkg::S_LANE_STORE:
            begin
                if (idx_reg == 2'd3)
                    state_next = stat.last ? xxh_pkg::S_MERGE : xxh_pkg::S_IDLE;
                else
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = xxh_pkg::S_LANE_MUL;
                end
            end
            xxh_pkg::S_MERGE:     state_next = xxh_pkg::S_ADD_LEN;
            xxh_pkg::S_ADD_LEN, xxh_pkg::S_WT_MOVE:
            begin
                if (pick[2])
                begin
                    idx_next   = pick[1:0];
                    state_next = xxh_pkg::S_WT_MUL;
                end
                else if (bt_any)
                begin
                    idx_next   = 2'd0;
                    state_next = xxh_pkg::S_BT_MUL;
                end
                else
                    state_next = xxh_pkg::S_AV_XOR;
            end
            xxh_pkg::S_WT_MUL:    state_next = xxh_pkg::S_WT_ADD;
            xxh_pkg::S_WT_ADD:    state_next = xxh_pkg::S_WT_MUL4;
            xxh_pkg::S_WT_MUL4:   state_next = xxh_pkg::S_WT_MOVE;
            xxh_pkg::S_BT_MUL:    state_next = xxh_pkg::S_BT_ADD;
            xxh_pkg::S_BT_ADD:    state_next = xxh_pkg::S_BT_MUL1;
            xxh_pkg::S_BT_MUL1:   state_next = xxh_pkg::S_BT_MOVE;
            xxh_pkg::S_BT_MOVE:
            begin
                if (({1'b0, idx_reg} + 3'd1) < stat.cnt)
                begin
                    idx_next   = idx_reg + 2'd1;
                    state_next = xxh_pkg::S_BT_MUL;
                end
                else
                    state_next = xxh_pkg::S_AV_XOR;
            end
            xxh_pkg::S_AV_XOR:    state_next = xxh_pkg::S_AV_MUL2;
            xxh_pkg::S_AV_MUL2:   state_next = xxh_pkg::S_AV_MIX;
            xxh_pkg::S_AV_MIX:    state_next = xxh_pkg::S_AV_MUL3;
            xxh_pkg::S_AV_MUL3:   state_next = xxh_pkg::S_DONE;
            xxh_pkg::S_DONE:
            begin
                if (can_load)
                begin
                    state_next     = xxh_pkg::S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:              state_next = xxh_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = xxh_pkg::DP_NOP;
        cmd.sel  = idx_reg;
        in_ready = 1'b0;
        case (state_reg)
            xxh_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = xxh_pkg::DP_ACCEPT;
            end
            xxh_pkg::S_DISPATCH:
            begin
                if (stat.absorb)
                    cmd.op = xxh_pkg::DP_START_STRIPE;
            end
            xxh_pkg::S_LANE_MUL:   cmd.op = xxh_pkg::DP_LANE_MUL;
            xxh_pkg::S_LANE_ADD:   cmd.op = xxh_pkg::DP_LANE_ADD;
            xxh_pkg::S_LANE_MUL1:  cmd.op = xxh_pkg::DP_MUL_P1;
            xxh_pkg::S_LANE_STORE: cmd.op = xxh_pkg::DP_LANE_STORE;
            xxh_pkg::S_MERGE:      cmd.op = xxh_pkg::DP_MERGE;
            xxh_pkg::S_ADD_LEN:    cmd.op = xxh_pkg::DP_ADD_LEN;
            xxh_pkg::S_WT_MUL:     cmd.op = xxh_pkg::DP_WT_MUL;
            xxh_pkg::S_WT_ADD:     cmd.op = xxh_pkg::DP_WT_ADD;
            xxh_pkg::S_WT_MUL4:    cmd.op = xxh_pkg::DP_MUL_P4;
            xxh_pkg::S_WT_MOVE:    cmd.op = xxh_pkg::DP_MOVE;
            xxh_pkg::S_BT_MUL:     cmd.op = xxh_pkg::DP_BT_MUL;
            xxh_pkg::S_BT_ADD:     cmd.op = xxh_pkg::DP_BT_ADD;
            xxh_pkg::S_BT_MUL1:    cmd.op = xxh_pkg::DP_MUL_P1;
            xxh_pkg::S_BT_MOVE:    cmd.op = xxh_pkg::DP_MOVE;
            xxh_pkg::S_AV_XOR:     cmd.op = xxh_pkg::DP_AV_XOR;
            xxh_pkg::S_AV_MUL2:    cmd.op = xxh_pkg::DP_MUL_P2;
            xxh_pkg::S_AV_MIX:     cmd.op = xxh_pkg::DP_AV_MIX;
            xxh_pkg::S_AV_MUL3:    cmd.op = xxh_pkg::DP_MUL_P3;
            xxh_pkg::S_DONE:
            begin
                if (can_load)
                    cmd.op = xxh_pkg::DP_FINISH;
            end
            default:               cmd.op = xxh_pkg::DP_NOP;
        endcase
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= xxh_pkg::S_IDLE;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hw/rtl/xxh_dpath.sv
// Datapath for the xxHash32 core: lanes, stripe buffer, length, one shared
// 32x32 multiplier and the hash work register. Depends on xxh_pkg.
module xxh_dpath
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [31:0]        cfg_seed,
    input  logic [31:0]        data_word,
    input  logic [2:0]         byte_count,
    input  logic               last_word,
    input  xxh_pkg::ctrl_cmd_t cmd,
    output xxh_pkg::dp_stat_t  stat,
    output logic [31:0]        hash_value
);

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
        return (x << r) | (x >> (32 - r));
    endfunction

    logic [31:0] seed_reg;
    logic [31:0] lane_reg [4];
    logic [31:0] buf_reg [xxh_pkg::BUF_DEPTH];
    logic [1:0]  fill_reg;
    logic [31:0] len_reg;
    logic        seen_reg;
    logic [31:0] word_reg;
    logic [2:0]  cnt_reg;
    logic        last_reg;
    logic        absorb_reg;
    logic [31:0] h_reg, h_next;
    logic [31:0] m_reg;
    logic [31:0] hash_reg;

    logic        accept;
    logic [2:0]  cnt_eff;
    logic        absorb_in;
    logic [31:0] src_word;
    logic [7:0]  src_byte;
    logic [31:0] mul_a, mul_b, mul_res;
    logic        mul_en;
    logic [31:0] merge_sum;

    assign accept    = (cmd.op == xxh_pkg::DP_ACCEPT);
    assign cnt_eff   = (!last_word || (byte_count > 3'd4)) ? 3'd4 : byte_count;
    assign absorb_in = (cnt_eff == 3'd4) && (fill_reg == 2'd3);

    always_comb
    begin
        case (cmd.sel)
            2'd0:    src_word = buf_reg[0];
            2'd1:    src_word = buf_reg[1];
            2'd2:    src_word = buf_reg[2];
            default: src_word = word_reg;
        endcase
        case (cmd.sel)
            2'd0:    src_byte = word_reg[7:0];
            2'd1:    src_byte = word_reg[15:8];
            2'd2:    src_byte = word_reg[23:16];
            default: src_byte = word_reg[31:24];
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a  = h_reg;
        mul_b  = xxh_pkg::P1;
        mul_en = cmd.op inside {xxh_pkg::DP_LANE_MUL, xxh_pkg::DP_MUL_P1,
                                xxh_pkg::DP_WT_MUL, xxh_pkg::DP_MUL_P4,
                                xxh_pkg::DP_BT_MUL, xxh_pkg::DP_MUL_P2,
                                xxh_pkg::DP_MUL_P3};
        case (cmd.op)
            xxh_pkg::DP_LANE_MUL: begin mul_a = src_word;          mul_b = xxh_pkg::P2; end
            xxh_pkg::DP_WT_MUL:   begin mul_a = src_word;          mul_b = xxh_pkg::P3; end
            xxh_pkg::DP_BT_MUL:   begin mul_a = {24'd0, src_byte}; mul_b = xxh_pkg::P5; end
            xxh_pkg::DP_MUL_P4:   mul_b = xxh_pkg::P4;
            xxh_pkg::DP_MUL_P2:   mul_b = xxh_pkg::P2;
            xxh_pkg::DP_MUL_P3:   mul_b = xxh_pkg::P3;
            default:              mul_b = xxh_pkg::P1;
        endcase
    end

    assign mul_res   = mul_a * mul_b;
    assign merge_sum = rotl32(lane_reg[0], 1) + rotl32(lane_reg[1], 7)
                     + rotl32(lane_reg[2], 12) + rotl32(lane_reg[3], 18);

    always_comb
    begin
        h_next = h_reg;
        case (cmd.op)
            xxh_pkg::DP_LANE_ADD: h_next = rotl32(lane_reg[cmd.sel] + m_reg, 13);
            xxh_pkg::DP_WT_ADD:   h_next = rotl32(h_reg + m_reg, 17);
            xxh_pkg::DP_BT_ADD:   h_next = rotl32(h_reg + m_reg, 11);
            xxh_pkg::DP_MOVE:     h_next = m_reg;
            xxh_pkg::DP_MERGE:    h_next = seen_reg ? merge_sum : (seed_reg + xxh_pkg::P5);
            xxh_pkg::DP_ADD_LEN:  h_next = h_reg + len_reg;
            xxh_pkg::DP_AV_XOR:   h_next = h_reg ^ (h_reg >> 15);
            xxh_pkg::DP_AV_MIX:   h_next = m_reg ^ (m_reg >> 13);
            default:              h_next = h_reg;
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        if (mul_en)
            m_reg <= mul_res;
        if (accept)
            word_reg <= data_word;
        if (cmd.op == xxh_pkg::DP_FINISH)
            hash_reg <= m_reg ^ (m_reg >> 16);
        if (cmd.op == xxh_pkg::DP_START_STRIPE && !seen_reg)
        begin
            lane_reg[0] <= seed_reg + xxh_pkg::P1 + xxh_pkg::P2;
            lane_reg[1] <= seed_reg + xxh_pkg::P2;
            lane_reg[2] <= seed_reg;
            lane_reg[3] <= seed_reg - xxh_pkg::P1;
        end
        else if (cmd.op == xxh_pkg::DP_LANE_STORE)
            lane_reg[cmd.sel] <= m_reg;
        for (int i = 0; i < xxh_pkg::BUF_DEPTH; i++)
        begin
            if (accept && !absorb_in && !last_word && (fill_reg == 2'(i)))
                buf_reg[i] <= data_word;
        end
    end

    // message state and seed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= 32'd0;
            fill_reg   <= 2'd0;
            len_reg    <= 32'd0;
            seen_reg   <= 1'b0;
            cnt_reg    <= 3'd4;
            last_reg   <= 1'b0;
            absorb_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                seed_reg <= cfg_seed;
            if (accept)
            begin
                cnt_reg    <= cnt_eff;
                last_reg   <= last_word;
                absorb_reg <= absorb_in;
                len_reg    <= len_reg + {29'd0, cnt_eff};
                if (absorb_in)
                    fill_reg <= 2'd0;
                else if (!last_word)
                    fill_reg <= fill_reg + 2'd1;
            end
            if (cmd.op == xxh_pkg::DP_START_STRIPE)
                seen_reg <= 1'b1;
            if (cmd.op == xxh_pkg::DP_FINISH)
            begin
                fill_reg <= 2'd0;
                len_reg  <= 32'd0;
                seen_reg <= 1'b0;
            end
        end
    end

    assign stat.absorb = absorb_reg;
    assign stat.last   = last_reg;
    assign stat.fill   = fill_reg;
    assign stat.cnt    = cnt_reg;
    assign hash_value  = hash_reg;

endmodule
